[rtl/tcc_pkg.sv]
// Shared types and constants for the terminal cursor control block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tcc_pkg;

    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int KIND_W  = 5;
    localparam int PARAM_W = 16;
    localparam int TOFF_W  = 19;

    localparam logic [POS_W-1:0] TAB_SPACING = POS_W'(8);
    localparam logic [POS_W-1:0] TAB_MASK    = ~POS_W'(7);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(4096);

    localparam logic [KIND_W-1:0] KIND_IND = 5'd0;
    localparam logic [KIND_W-1:0] KIND_RI  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_BS  = 5'd2;
    localparam logic [KIND_W-1:0] KIND_HT  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_CR  = 5'd4;
    localparam logic [KIND_W-1:0] KIND_VPA = 5'd5;
    localparam logic [KIND_W-1:0] KIND_CUD = 5'd6;
    localparam logic [KIND_W-1:0] KIND_CUU = 5'd7;
    localparam logic [KIND_W-1:0] KIND_CUF = 5'd8;
    localparam logic [KIND_W-1:0] KIND_CUB = 5'd9;
    localparam logic [KIND_W-1:0] KIND_CBT = 5'd10;
    localparam logic [KIND_W-1:0] KIND_CHT = 5'd11;
    localparam logic [KIND_W-1:0] KIND_CVT = 5'd12;
    localparam logic [KIND_W-1:0] KIND_CNL = 5'd13;
    localparam logic [KIND_W-1:0] KIND_CPL = 5'd14;
    localparam logic [KIND_W-1:0] KIND_CHA = 5'd15;
    localparam logic [KIND_W-1:0] KIND_CUP = 5'd16;

    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [4:0] {
        OP_IND,
        OP_RI,
        OP_BS,
        OP_HT,
        OP_CR,
        OP_ROW_ABS,
        OP_DOWN,
        OP_UP,
        OP_RIGHT,
        OP_LEFT,
        OP_CBT,
        OP_CHT,
        OP_NEXT_LINE,
        OP_PREV_LINE,
        OP_COL_ABS,
        OP_CUP,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [PARAM_W-1:0] arg;
        logic [PARAM_W-1:0] arg_b;
        logic [TOFF_W-1:0]  tab_off;
        logic               two_tabs;
    } t_cmd;

endpackage

[rtl/tcc_front.sv]
// Front end: decodes an incoming word into a cursor command.
// Depends on tcc_pkg.
module tcc_front
    import tcc_pkg::*;
(
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [PARAM_W-1:0] i_param_a,
    input  logic [PARAM_W-1:0] i_param_b,
    output t_cmd               o_cmd
);

    logic [PARAM_W-1:0] count;
    logic [PARAM_W-1:0] pos_a;
    logic [PARAM_W-1:0] pos_b;
    logic [TOFF_W-1:0]  off_fwd;
    logic [TOFF_W-1:0]  off_back;
    logic               two;

    always_comb begin
        count    = (i_param_a == '0) ? PARAM_W'(1) : i_param_a;
        pos_a    = (i_param_a == '0) ? '0 : i_param_a - PARAM_W'(1);
        pos_b    = (i_param_b == '0) ? '0 : i_param_b - PARAM_W'(1);
        two      = (count >= PARAM_W'(2));
        off_fwd  = {TOFF_W'(count - PARAM_W'(1))} << 3;
        off_back = two ? ({TOFF_W'(count - PARAM_W'(2))} << 3) : '0;
    end

    always_comb begin
        o_cmd.arg      = count;
        o_cmd.arg_b    = pos_b;
        o_cmd.tab_off  = '0;
        o_cmd.two_tabs = two;
        unique case (i_kind)
            KIND_IND: o_cmd.op = OP_IND;
            KIND_RI:  o_cmd.op = OP_RI;
            KIND_BS:  o_cmd.op = OP_BS;
            KIND_HT:  o_cmd.op = OP_HT;
            KIND_CR:  o_cmd.op = OP_CR;
            KIND_VPA: begin
                o_cmd.op  = OP_ROW_ABS;
                o_cmd.arg = pos_a;
            end
            KIND_CUD: o_cmd.op = OP_DOWN;
            KIND_CVT: o_cmd.op = OP_DOWN;
            KIND_CUU: o_cmd.op = OP_UP;
            KIND_CUF: o_cmd.op = OP_RIGHT;
            KIND_CUB: o_cmd.op = OP_LEFT;
            KIND_CBT: begin
                o_cmd.op      = OP_CBT;
                o_cmd.tab_off = off_back;
            end
            KIND_CHT: begin
                o_cmd.op      = OP_CHT;
                o_cmd.tab_off = off_fwd;
            end
            KIND_CNL: o_cmd.op = OP_NEXT_LINE;
            KIND_CPL: o_cmd.op = OP_PREV_LINE;
            KIND_CHA: begin
                o_cmd.op  = OP_COL_ABS;
                o_cmd.arg = pos_a;
            end
            KIND_CUP: begin
                o_cmd.op  = OP_CUP;
                o_cmd.arg = pos_a;
            end
            default:  o_cmd.op = OP_NOP;
        endcase
    end

endmodule

[rtl/tcc_queue.sv]
// Short command queue between the front end and the back end.
// Depends on tcc_pkg for the command type.
module tcc_queue
    import tcc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_wr_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && i_wr && !i_rd) |=> 1'b0)
        else $error("queue written while full");

endmodule

[rtl/tcc_back.sv]
// Back end: applies cursor commands to the stored position and holds the result word.
// Depends on tcc_pkg.
module tcc_back
    import tcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_col_max,
    input  logic [POS_W-1:0] i_row_max,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [POS_W-1:0] o_cursor_column,
    output logic [POS_W-1:0] o_cursor_row,
    output logic [1:0]       o_scroll_request
);

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [1:0]       r_scroll, n_scroll;
    logic             r_valid;
    logic             advance;

    logic [POS_W-1:0] bt1;
    logic [POS_W-1:0] bt2;
    logic [POS_W:0]   fwd;
    logic [19:0]      row_sum;
    logic [19:0]      col_sum;
    logic [19:0]      cht_sum;

    function automatic logic [POS_W-1:0] clamp(input logic [19:0] v,
                                               input logic [POS_W-1:0] m);
        clamp = (v > {8'b0, m}) ? m : v[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sub_floor(input logic [POS_W-1:0] p,
                                                   input logic [PARAM_W-1:0] n,
                                                   input logic [POS_W-1:0] m);
        if ({4'b0, p} < n) begin
            sub_floor = '0;
        end else begin
            sub_floor = clamp(20'(p - n[POS_W-1:0]), m);
        end
    endfunction

    assign advance  = !i_cmd_empty && (!r_valid || i_pop);
    assign o_cmd_rd = advance;

    always_comb begin
        fwd     = {1'b0, r_col & TAB_MASK} + {1'b0, TAB_SPACING};
        cht_sum = 20'(fwd) + 20'(i_cmd.tab_off);
        row_sum = 20'(r_row) + 20'(i_cmd.arg);
        col_sum = 20'(r_col) + 20'(i_cmd.arg);
        bt1     = clamp((r_col == '0) ? '0 : 20'((r_col - POS_W'(1)) & TAB_MASK),
                        i_col_max);
        bt2     = (bt1 == '0) ? '0 : ((bt1 - POS_W'(1)) & TAB_MASK);
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_scroll = SCROLL_NONE;
        unique case (i_cmd.op)
            OP_IND: begin
                if (r_row >= i_row_max) begin
                    n_row    = i_row_max;
                    n_scroll = SCROLL_UP;
                end else begin
                    n_row = r_row + POS_W'(1);
                end
            end
            OP_RI: begin
                if (r_row == '0) begin
                    n_scroll = SCROLL_DOWN;
                end else begin
                    n_row = clamp(20'(r_row - POS_W'(1)), i_row_max);
                end
            end
            OP_BS: n_col = (r_col == '0) ? '0
                         : clamp(20'(r_col - POS_W'(1)), i_col_max);
            OP_HT: n_col = clamp(20'(fwd), i_col_max);
            OP_CR: n_col = '0;
            OP_ROW_ABS: n_row = clamp(20'(i_cmd.arg), i_row_max);
            OP_DOWN: n_row = clamp(row_sum, i_row_max);
            OP_UP: n_row = sub_floor(r_row, i_cmd.arg, i_row_max);
            OP_RIGHT: n_col = clamp(col_sum, i_col_max);
            OP_LEFT: n_col = sub_floor(r_col, i_cmd.arg, i_col_max);
            OP_CBT: begin
                if (!i_cmd.two_tabs) begin
                    n_col = bt1;
                end else if (20'(bt2) < 20'(i_cmd.tab_off)) begin
                    n_col = '0;
                end else begin
                    n_col = bt2 - i_cmd.tab_off[POS_W-1:0];
                end
            end
            OP_CHT: n_col = clamp(cht_sum, i_col_max);
            OP_NEXT_LINE: begin
                n_row = clamp(row_sum, i_row_max);
                n_col = '0;
            end
            OP_PREV_LINE: begin
                n_row = sub_floor(r_row, i_cmd.arg, i_row_max);
                n_col = '0;
            end
            OP_COL_ABS: n_col = clamp(20'(i_cmd.arg), i_col_max);
            OP_CUP: begin
                n_row = clamp(20'(i_cmd.arg), i_row_max);
                n_col = clamp(20'(i_cmd.arg_b), i_col_max);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_scroll <= SCROLL_NONE;
            r_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_scroll <= n_scroll;
                r_valid  <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty          = !r_valid;
    assign o_cursor_column  = r_col;
    assign o_cursor_row     = r_row;
    assign o_scroll_request = r_scroll;

    a_scroll_up_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_scroll == SCROLL_UP) |-> (r_row == i_row_max))
        else $error("scroll up without cursor on bottom row");

    a_scroll_down_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_scroll == SCROLL_DOWN) |-> (r_row == '0))
        else $error("scroll down without cursor on top row");

    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_valid)
        else $error("executed command produced no result word");

endmodule

[rtl/terminal_cursor_control.sv]
// Terminal cursor control: tracks an ECMA-48 text cursor and returns one result word per
// command word. A word is decoded on entry, passes a small command queue and is applied in
// the back end, whose result register feeds the output; one word per cycle is sustained
// while results are popped and the queue does not fill. An accepted word is written into
// the queue and then applied to the result register. The rate is set by the position
// update in the back end. Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
module terminal_cursor_control
    import tcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [PARAM_W-1:0]  i_param_a,
    input  logic [PARAM_W-1:0]  i_param_b,
    output logic                empty,
    input  logic                pop,
    output logic [POS_W-1:0]    o_cursor_column,
    output logic [POS_W-1:0]    o_cursor_row,
    output logic [1:0]          o_scroll_request,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    t_cmd             front_cmd;
    t_cmd             head_cmd;
    logic             q_empty;
    logic             q_rd;
    logic             wr;
    logic [POS_W-1:0] r_col_max;
    logic [POS_W-1:0] r_row_max;

    function automatic logic [POS_W-1:0] size_to_max(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            size_to_max = '0;
        end else if (v > SIZE_LIMIT) begin
            size_to_max = '1;
        end else begin
            size_to_max = POS_W'(v - SIZE_W'(1));
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign wr          = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_max <= POS_W'(79);
            r_row_max <= POS_W'(23);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SCREEN_WIDTH) begin
                r_col_max <= size_to_max(i_cfg_data);
            end
            if (i_cfg_index == CFG_SCREEN_HEIGHT) begin
                r_row_max <= size_to_max(i_cfg_data);
            end
        end
    end

    tcc_front u_front (
        .i_kind    (i_kind),
        .i_param_a (i_param_a),
        .i_param_b (i_param_b),
        .o_cmd     (front_cmd)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    tcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_col_max        (r_col_max),
        .i_row_max        (r_row_max),
        .i_cmd            (head_cmd),
        .i_cmd_empty      (q_empty),
        .o_cmd_rd         (q_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_scroll_request (o_scroll_request)
    );

endmodule
